[sv/rps_pkg.sv]
// Package for rolling_price_signals: constants, parameter defaults and helpers.
`default_nettype none
package rps_pkg;
    localparam int MOM_LB_DEF = 5;
    localparam int MR_LB_DEF  = 3;
    localparam int VOL_LB_DEF = 10;
    localparam logic [31:0] ONE_Q24       = 32'h0100_0000;
    localparam logic [31:0] VOL_FLOOR_Q24 = 32'd16777;
    localparam logic [3:0]  IDX_MAX       = 4'd15;

    function automatic int max3(input int a, input int b, input int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic int clog2m(input int v);
        int r;
        r = 1;
        while ((1 << r) < v) r = r + 1;
        return r;
    endfunction

    // Saturate a signed ratio given as magnitude and sign (64-bit magnitude).
    function automatic logic [31:0] sat_ratio(input logic [63:0] mag, input logic neg);
        logic [31:0] res;
        if (neg) begin
            res = (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end else begin
            res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return res;
    endfunction
endpackage
`default_nettype wire

[sv/rps_if.sv]
// Valid/ready stream interfaces for the price input and the signal output.
`default_nettype none
interface rps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] close_price;
    logic        new_series;
    modport source (output valid, output close_price, output new_series, input ready);
    modport sink   (input valid, input close_price, input new_series, output ready);
endinterface

interface rps_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] momentum;
    logic signed [31:0] mean_reversion;
    logic        [31:0] volatility;
    modport source (output valid, output momentum, output mean_reversion, output volatility,
                    input ready);
    modport sink   (input valid, input momentum, input mean_reversion, input volatility,
                    output ready);
endinterface
`default_nettype wire

[sv/rps_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle, shared by all ratios.
`default_nettype none
module rps_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [127:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [127:0]     o_quo
);
    logic [127:0] r_quo;
    logic [63:0]  r_rem;
    logic [63:0]  r_den;
    logic [7:0]   r_cnt;
    logic         r_busy;
    logic [64:0]  w_shift;
    logic [64:0]  w_diff;

    assign w_shift = {r_rem[63:0], r_quo[127]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'd128;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[64]) begin
                    r_rem <= w_diff[63:0];
                    r_quo <= {r_quo[126:0], 1'b1};
                end else begin
                    r_rem <= w_shift[63:0];
                    r_quo <= {r_quo[126:0], 1'b0};
                end
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;
endmodule
`default_nettype wire

[sv/rolling_price_signals.sv]
// Top level: rolling momentum, mean-reversion and volatility over one price series.
//  channel   dir  payload                                   handshake
//  i_in      in   close_price[31:0], new_series              valid/ready
//  o_out     out  momentum, mean_reversion, volatility       valid/ready
// One request at a time; its run time is set by the shared 128-step divider
// (up to 3 + VOL_LB divisions) and a 32-step square root.
// History lives in one memory with a registered read; reads walk the entries in turn.
// Reset clears the sample count and sweeps the memory to zero.
// A waiting result holds while the output stalls; no new request is taken meanwhile.
`default_nettype none
module rolling_price_signals #(
    parameter int MOM_LB = rps_pkg::MOM_LB_DEF,
    parameter int MR_LB  = rps_pkg::MR_LB_DEF,
    parameter int VOL_LB = rps_pkg::VOL_LB_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rps_in_if.sink    i_in,
    rps_out_if.source o_out
);
    import rps_pkg::*;
    localparam int HIST = max3(MOM_LB + 1, MR_LB, VOL_LB + 1);
    localparam int AW   = clog2m(HIST);
    localparam int NW   = clog2m(VOL_LB + 1);

    localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,  S_SHR  = 5'd2,  S_SHW = 5'd3,
                           S_MOMR = 5'd4,  S_MOMD = 5'd5,  S_MRR  = 5'd6,  S_MRA = 5'd7,
                           S_MRD  = 5'd8,  S_VR0  = 5'd9,  S_VR1  = 5'd10, S_VDW = 5'd11,
                           S_VACC = 5'd12, S_VSQ  = 5'd13, S_VCUB = 5'd14, S_VVAR = 5'd15,
                           S_SQRT = 5'd16, S_OUT  = 5'd17, S_VCHK = 5'd18, S_VQ   = 5'd19,
                           S_VSQH = 5'd20;

    logic [31:0]   mem [HIST];
    logic [31:0]   r_rd;
    logic [AW-1:0] r_ra;
    logic          r_we;
    logic [AW-1:0] r_wa;
    logic [31:0]   r_wd;

    logic [4:0]    r_st;
    logic [3:0]    r_idx;
    logic [31:0]   r_price, r_a;
    logic [35:0]   r_sum;
    logic [AW-1:0] r_k;
    logic [NW-1:0] r_n;
    logic signed [31:0] r_ret [VOL_LB];
    logic signed [39:0] r_s1;
    logic [127:0]  r_acc;
    logic [39:0]   r_m;
    logic [63:0]   r_var, r_res, r_bit;
    logic [5:0]    r_sc;
    logic [31:0]   r_mom, r_mr, r_vol;
    logic          r_neg, r_ovalid, r_clr;
    logic          r_pass;

    logic          d_start, d_done;
    logic [127:0]  d_num, d_quo;
    logic [63:0]   d_den;

    rps_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start), .i_num(d_num),
                   .i_den(d_den), .o_done(d_done), .o_quo(d_quo));

    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_wa] <= r_wd;
        r_rd <= mem[r_ra];
    end

    logic [63:0] w_pl;
    logic signed [39:0] w_d;
    logic [63:0] w_sqt;
    logic [63:0] w_lsq;
    logic [48:0] w_hsq;
    assign w_pl  = 64'(MR_LB) * {32'd0, r_price};
    assign w_d   = $signed({1'b0, r_n}) * r_ret[r_k] - r_s1;
    assign w_sqt = r_res + r_bit;
    // square split as low limb squared plus high limb times (m + low limb), shifted
    assign w_lsq = r_m[31:0] * r_m[31:0];
    assign w_hsq = r_m[39:32] * ({1'b0, r_m} + {9'd0, r_m[31:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_idx <= '0; r_ovalid <= 1'b0; r_we <= 1'b1;
            r_wa <= '0; r_wd <= '0; r_ra <= '0; r_k <= '0; d_start <= 1'b0;
            r_clr <= 1'b0; r_pass <= 1'b0;
        end else begin
            d_start <= 1'b0;
            r_we    <= 1'b0;
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            case (r_st)
                S_CLR: begin
                    r_we <= 1'b1; r_wd <= '0;
                    r_wa <= r_k;
                    if (r_k == AW'(HIST - 1)) r_st <= S_IDLE;
                    else r_k <= r_k + AW'(1);
                end
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    r_price <= i_in.close_price;
                    r_clr   <= i_in.new_series;
                    if (i_in.new_series) r_idx <= '0;
                    r_k  <= AW'(HIST - 1);
                    r_ra <= AW'(HIST - 2);
                    r_st <= S_SHR;
                end
                S_SHR: r_st <= S_SHW;
                S_SHW: begin
                    r_we <= 1'b1; r_wa <= r_k; r_wd <= r_clr ? 32'd0 : r_rd;
                    if (r_k == AW'(1)) begin
                        r_st <= S_MOMR;
                    end else begin
                        r_k  <= r_k - AW'(1);
                        r_ra <= r_k - AW'(2);
                        r_st <= S_SHR;
                    end
                end
                S_MOMR: begin
                    r_we <= 1'b1; r_wa <= '0; r_wd <= r_price;
                    r_ra <= AW'(MOM_LB);
                    r_mom <= '0;
                    r_st <= S_MOMD;
                    r_pass <= 1'b0;
                end
                S_MOMD: begin
                    if (!r_pass) begin
                        r_pass <= 1'b1;
                    end else begin
                        if (r_idx >= 4'(MOM_LB) && r_rd != '0) begin
                            r_neg   <= r_price < r_rd;
                            d_num   <= {72'd0, (r_price < r_rd ? r_rd - r_price
                                                 : r_price - r_rd), 24'd0};
                            d_den   <= {32'd0, r_rd};
                            d_start <= 1'b1;
                            r_st    <= S_MRR;
                            r_a     <= 32'd1;
                        end else begin
                            r_a  <= 32'd0;
                            r_st <= S_MRR;
                        end
                        r_pass <= 1'b0;
                    end
                end
                S_MRR: begin
                    if (r_a == 32'd0 || d_done) begin
                        if (d_done) r_mom <= sat_ratio(d_quo[63:0], r_neg);
                        r_sum <= '0; r_k <= '0; r_ra <= '0; r_mr <= '0;
                        r_st <= S_MRA; r_pass <= 1'b0;
                    end
                end
                S_MRA: begin
                    if (!r_pass) begin
                        r_pass <= 1'b1;
                        r_ra <= r_k + AW'(1);
                    end else begin
                        r_sum <= r_sum + {4'd0, r_rd};
                        if (r_k == AW'(MR_LB - 1)) begin
                            r_st <= S_MRD; r_pass <= 1'b0;
                        end else begin
                            r_k <= r_k + AW'(1);
                            r_ra <= r_k + AW'(2);
                        end
                    end
                end
                S_MRD: begin
                    if (!r_pass) begin
                        r_pass <= 1'b1;
                        if ((5'(r_idx) + 5'd1) >= 5'(MR_LB) && r_sum != '0) begin
                            r_neg   <= {28'd0, r_sum} < w_pl;
                            d_num   <= {40'd0, ({28'd0, r_sum} < w_pl ? w_pl - {28'd0, r_sum}
                                                 : {28'd0, r_sum} - w_pl), 24'd0};
                            d_den   <= {28'd0, r_sum};
                            d_start <= 1'b1;
                            r_a     <= 32'd1;
                        end else r_a <= 32'd0;
                    end else if (r_a == 32'd0 || d_done) begin
                        if (d_done) r_mr <= sat_ratio(d_quo[63:0], r_neg);
                        r_vol <= ONE_Q24; r_n <= '0; r_s1 <= '0; r_k <= '0;
                        r_ra <= '0; r_pass <= 1'b0;
                        r_st <= (r_idx >= 4'(VOL_LB)) ? S_VR0 : S_OUT;
                    end
                end
                S_VR0: begin
                    r_ra <= r_k + AW'(1);
                    r_st <= S_VR1;
                end
                S_VR1: begin
                    r_a <= r_rd;
                    r_st <= S_VCHK;
                end
                S_VCHK: begin
                    if (r_rd != '0) begin
                        r_neg   <= r_a < r_rd;
                        d_num   <= {72'd0, (r_a < r_rd ? r_rd - r_a : r_a - r_rd), 24'd0};
                        d_den   <= {32'd0, r_rd};
                        d_start <= 1'b1;
                        r_st    <= S_VDW;
                        r_pass  <= 1'b0;
                    end else if (r_k == AW'(VOL_LB - 1)) begin
                        r_st <= S_VQ;
                    end else begin
                        r_k <= r_k + AW'(1); r_ra <= r_k + AW'(1); r_st <= S_VR0;
                    end
                end
                S_VDW: if (d_done) begin
                    r_ret[r_n] <= $signed(sat_ratio(d_quo[63:0], r_neg));
                    r_s1 <= r_s1 + 40'($signed(sat_ratio(d_quo[63:0], r_neg)));
                    r_n  <= r_n + NW'(1);
                    if (r_k == AW'(VOL_LB - 1)) r_st <= S_VQ;
                    else begin
                        r_k <= r_k + AW'(1); r_ra <= r_k + AW'(1); r_st <= S_VR0;
                    end
                end
                S_VQ: begin
                    r_acc <= '0; r_k <= '0;
                    r_st <= (r_n == '0) ? S_OUT : S_VACC;
                end
                S_VACC: begin
                    r_m  <= w_d[39] ? 40'(-w_d) : 40'(w_d);
                    r_st <= S_VSQ;
                end
                S_VSQ: begin
                    r_acc <= r_acc + {64'd0, w_lsq};
                    r_st  <= S_VSQH;
                end
                S_VSQH: begin
                    r_acc <= r_acc + {47'd0, w_hsq, 32'd0};
                    if (r_k == AW'(r_n - NW'(1))) r_st <= S_VCUB;
                    else begin
                        r_k <= r_k + AW'(1); r_st <= S_VACC;
                    end
                end
                S_VCUB: begin
                    d_num   <= r_acc;
                    d_den   <= 64'(12'(r_n) * 12'(r_n) * 12'(r_n));
                    d_start <= 1'b1;
                    r_st    <= S_VVAR;
                end
                S_VVAR: if (d_done) begin
                    r_var <= (d_quo[127:64] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : d_quo[63:0];
                    r_res <= '0; r_bit <= 64'h4000_0000_0000_0000; r_sc <= 6'd32;
                    r_st  <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_var >= w_sqt) begin
                        r_var <= r_var - w_sqt;
                        r_res <= (r_res >> 1) + r_bit;
                    end else r_res <= r_res >> 1;
                    r_bit <= r_bit >> 2;
                    r_sc  <= r_sc - 6'd1;
                    if (r_sc == 6'd1) r_st <= S_OUT;
                end
                S_OUT: begin
                    if (r_idx >= 4'(VOL_LB) && r_n != '0) begin
                        if (r_res[63:32] != '0) r_vol <= 32'hFFFF_FFFF;
                        else if (r_res[31:0] < VOL_FLOOR_Q24) r_vol <= VOL_FLOOR_Q24;
                        else r_vol <= r_res[31:0];
                    end
                    r_idx <= (r_idx < IDX_MAX) ? r_idx + 4'd1 : IDX_MAX;
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_st == S_IDLE) && !r_ovalid;
    assign o_out.valid          = r_ovalid;
    assign o_out.momentum       = r_mom;
    assign o_out.mean_reversion = r_mr;
    assign o_out.volatility     = r_vol;

    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !o_out.valid) else $error("request taken with result held");
    a_vol_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.volatility >= VOL_FLOOR_Q24)) else $error("volatility below floor");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_start |=> !d_done) else $error("divider finished too soon");
endmodule
`default_nettype wire
